// ----- hw/rtl/lpmd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared widths and parameter defaults for the length prefixed message
// deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TYPE_W = 8;
  localparam int unsigned LEN_W  = 16;

  localparam int unsigned TYPE_BYTES_DEF = 1;
  localparam int unsigned LEN_BYTES_DEF  = 2;

endpackage

`default_nettype wire

// ----- hw/rtl/lpmd_if.sv -----
// ----------------------------------------------------------------------------
// lpmd channel interfaces
// Valid/ready channels of the deframer: byte input, message output and the
// configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpmd_byte_if;
  import lpmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpmd_msg_if;
  import lpmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              in_header;
  logic [TYPE_W-1:0] msg_type;
  logic [LEN_W-1:0]  content_length;
  logic              last;

  modport source (output valid, output out_byte, output in_header, output msg_type,
                  output content_length, output last, input ready);
  modport sink   (input valid, input out_byte, input in_header, input msg_type,
                  input content_length, input last, output ready);
endinterface

interface lpmd_cfg_if;
  logic valid;
  logic ready;
  logic length_big_endian;

  modport source (output valid, output length_big_endian, input ready);
  modport sink   (input valid, input length_big_endian, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/length_prefixed_message_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Splits a byte stream into type/length prefixed messages and tags every
// byte with header flag, type, length and end-of-message flag.
// ----------------------------------------------------------------------------
//
//   port     dir   transaction
//   -------  ----  ---------------------------------------------------------
//   byte_i   in    one stream byte (data_byte)
//   msg_o    out   one tagged byte (out_byte, in_header, msg_type,
//                  content_length, last)
//   cfg_i    in    length_big_endian register write
//
// One byte per cycle unless msg_o stalls: a byte is taken in the cycle after the previous one.
// An accepted byte reaches msg_o through the output register.
// byte_i.ready drops only while msg_o holds a result and msg_o.ready is low.
// Reset clears the header position, accumulators, remaining count and the
// byte order register (little endian).
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_message_deframer #(
  parameter int unsigned TYPE_BYTES = lpmd_pkg::TYPE_BYTES_DEF,
  parameter int unsigned LEN_BYTES  = lpmd_pkg::LEN_BYTES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lpmd_byte_if.sink  byte_i,
  lpmd_msg_if.source msg_o,
  lpmd_cfg_if.sink   cfg_i
);
  import lpmd_pkg::*;

  localparam int unsigned HdrBytes = TYPE_BYTES + LEN_BYTES;
  localparam int unsigned IdxW     = $clog2(HdrBytes);

  logic             big_endian_q;
  logic [IdxW-1:0]  hdr_idx_q, hdr_idx_d;
  logic [TYPE_W-1:0] type_q, type_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] rem_q, rem_d;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_hdr_q;
  logic [TYPE_W-1:0] out_type_q;
  logic [LEN_W-1:0]  out_len_q;
  logic              out_last_q;

  logic              accept;
  logic              hdr;
  logic              last;
  logic [TYPE_W-1:0] type_base;
  logic [LEN_W-1:0]  len_base;
  logic [IdxW-1:0]   len_pos;
  logic [BYTE_W-1:0] b;

  assign byte_i.ready = !out_valid_q || msg_o.ready;
  assign accept       = byte_i.valid && byte_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign b            = byte_i.data_byte;

  always_comb begin
    hdr_idx_d = hdr_idx_q;
    type_d    = type_q;
    len_d     = len_q;
    rem_d     = rem_q;
    hdr       = 1'b0;
    last      = 1'b0;
    type_base = (hdr_idx_q == '0) ? '0 : type_q;
    len_base  = (hdr_idx_q == '0) ? '0 : len_q;
    len_pos   = IdxW'(32'(hdr_idx_q) - TYPE_BYTES);
    if (rem_q != '0) begin
      last  = (rem_q == LEN_W'(1));
      rem_d = rem_q - LEN_W'(1);
    end else begin
      hdr    = 1'b1;
      type_d = type_base;
      len_d  = len_base;
      if (32'(hdr_idx_q) < TYPE_BYTES) begin
        if (big_endian_q) begin
          type_d = b;
        end else if (hdr_idx_q == '0) begin
          type_d = type_base | b;
        end
      end else begin
        if (big_endian_q) begin
          len_d = {len_base[LEN_W-BYTE_W-1:0], b};
        end else if (len_pos == '0) begin
          len_d = len_base | LEN_W'(b);
        end else if (len_pos == IdxW'(1)) begin
          len_d = len_base | {b, {BYTE_W{1'b0}}};
        end
      end
      if (32'(hdr_idx_q) == HdrBytes - 1) begin
        hdr_idx_d = '0;
        rem_d     = len_d;
        last      = (len_d == '0);
      end else begin
        hdr_idx_d = hdr_idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
      hdr_idx_q    <= '0;
      type_q       <= '0;
      len_q        <= '0;
      rem_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        big_endian_q <= cfg_i.length_big_endian;
      end
      if (accept) begin
        hdr_idx_q   <= hdr_idx_d;
        type_q      <= type_d;
        len_q       <= len_d;
        rem_q       <= rem_d;
        out_valid_q <= 1'b1;
      end else if (msg_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_byte_q <= b;
      out_hdr_q  <= hdr;
      out_type_q <= type_d;
      out_len_q  <= len_d;
      out_last_q <= last;
    end
  end

  assign msg_o.valid          = out_valid_q;
  assign msg_o.out_byte       = out_byte_q;
  assign msg_o.in_header      = out_hdr_q;
  assign msg_o.msg_type       = out_type_q;
  assign msg_o.content_length = out_len_q;
  assign msg_o.last           = out_last_q;

`ifndef NO_ASSERTIONS
  a_rem_only_at_hdr_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != '0 |-> hdr_idx_q == '0)
    else $error("content pending in the middle of a header");

  a_last_content_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rem_q == LEN_W'(1) |=> msg_o.valid && msg_o.last && !msg_o.in_header)
    else $error("final content byte not flagged last");

  a_hdr_last_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_o.valid && msg_o.in_header && msg_o.last |-> msg_o.content_length == '0)
    else $error("header byte flagged last with nonzero length");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_length_prefixed_message_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_length_prefixed_message_deframer
// Feeds type/length framed byte streams into the deframer in both byte
// orders and checks every tagged output byte against a cycle-free model of
// the framing state. Covers zero-length messages, a maximum length field,
// back pressure that fills the block, and random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_length_prefixed_message_deframer;
  import lpmd_pkg::*;

  localparam int unsigned N_TYPE      = TYPE_BYTES_DEF;
  localparam int unsigned N_LEN       = LEN_BYTES_DEF;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RAND_BYTES  = 420;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned MAX_TAIL    = 64;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              hdr;
    logic [TYPE_W-1:0] mtype;
    logic [LEN_W-1:0]  mlen;
    logic              eom;
  } msg_beat_t;

  logic clk_i;
  logic rst_ni;

  lpmd_byte_if byte_ch ();
  lpmd_msg_if  msg_ch ();
  lpmd_cfg_if  cfg_ch ();

  length_prefixed_message_deframer #(
    .TYPE_BYTES(N_TYPE),
    .LEN_BYTES (N_LEN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .byte_i(byte_ch),
    .msg_o (msg_ch),
    .cfg_i (cfg_ch)
  );

  // framing state of the model
  bit                be_order;
  int unsigned       hdr_pos;
  logic [TYPE_W-1:0] type_sum;
  logic [LEN_W-1:0]  len_sum;
  logic [LEN_W-1:0]  body_left;

  msg_beat_t pending_beats[$];

  bit          idle_on;
  bit          hold_req;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned beats_checked;
  int unsigned msgs_closed;
  int unsigned cfg_writes;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] fold_in(input logic [31:0] acc,
                                          input logic [7:0] b,
                                          input int unsigned pos);
    if (be_order) return {acc[23:0], b};
    if (pos < 4) return acc | (32'(b) << (8 * pos));
    return acc;
  endfunction

  task automatic predict_beat(input logic [BYTE_W-1:0] b);
    msg_beat_t   e;
    int unsigned pos;
    e      = '0;
    e.data = b;
    if (body_left != 0) begin
      e.eom     = (body_left == 1);
      body_left = body_left - 1'b1;
    end else begin
      pos   = hdr_pos;
      e.hdr = 1'b1;
      if (pos == 0) begin
        type_sum = '0;
        len_sum  = '0;
      end
      if (pos < N_TYPE) type_sum = TYPE_W'(fold_in(32'(type_sum), b, pos));
      else len_sum = LEN_W'(fold_in(32'(len_sum), b, pos - N_TYPE));
      if (pos + 1 >= N_TYPE + N_LEN) begin
        hdr_pos   = 0;
        body_left = len_sum;
        if (len_sum == 0) e.eom = 1'b1;
      end else begin
        hdr_pos = pos + 1;
      end
    end
    e.mtype = type_sum;
    e.mlen  = len_sum;
    pending_beats.insert(pending_beats.size(), e);
  endtask

  // one byte transaction; entered and left just after a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      byte_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid     = 1'b1;
    byte_ch.data_byte = b;
    do @(posedge clk_i); while (!byte_ch.ready);
    predict_beat(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_field(input logic [31:0] val, input int unsigned nbytes);
    int unsigned sh;
    for (int unsigned i = 0; i < nbytes; i++) begin
      sh = be_order ? nbytes - 1 - i : i;
      send_byte(val[8*sh +: 8]);
    end
  endtask

  task automatic send_message(input logic [31:0] mtype, input logic [31:0] mlen);
    send_field(mtype, N_TYPE);
    send_field(mlen, N_LEN);
    for (int unsigned i = 0; i < mlen[LEN_W-1:0]; i++) send_byte(8'($urandom));
  endtask

  task automatic wait_drained();
    byte_ch.valid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_byte_order(input bit be);
    wait_drained();
    cfg_ch.length_big_endian = be;
    cfg_ch.valid             = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    be_order = be;
    cfg_writes++;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic test_little_endian();
    idle_on = 1'b1;
    set_byte_order(1'b0);
    send_message(32'hFF, 32'h0000);
    send_message(32'h00, 32'h0001);
    send_message(32'h81, 32'h0100);
  endtask

  task automatic test_big_endian();
    set_byte_order(1'b1);
    send_message(32'hA5, 32'h0002);
    send_message(32'h5A, 32'h0000);
    send_message(32'h7E, 32'h0001);
  endtask

  // all-ones length field; the stream ends inside this body
  task automatic test_max_length();
    idle_on = 1'b0;
    set_byte_order(1'b1);
    send_field(32'($urandom), N_TYPE);
    send_field(32'hFFFF_FFFF, N_LEN);
    for (int unsigned i = 0; i < MAX_TAIL; i++) send_byte(8'($urandom));
    idle_on = 1'b1;
  endtask

  task automatic test_back_pressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_message(32'($urandom), 32'($urandom_range(0, 6)));
    while (hold_req) @(negedge clk_i);
    idle_on = 1'b1;
  endtask

  task automatic test_random_streams();
    int unsigned stop_at;
    int unsigned r;
    logic [31:0] mlen;
    for (int p = 0; p < PHASES; p++) begin
      set_byte_order(p < 2 ? p[0] : 1'($urandom_range(0, 1)));
      idle_on = (p != 2) && (p != 4);
      stop_at = bytes_sent + RAND_BYTES / PHASES;
      while (bytes_sent < stop_at) begin
        r = $urandom_range(0, 9);
        if (r < 2) mlen = 0;
        else if (r < 8) mlen = $urandom_range(1, 8);
        else if (r < 9) mlen = $urandom_range(9, 40);
        else mlen = $urandom_range(41, 200);
        send_message(32'($urandom), mlen);
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic check_beat(input msg_beat_t e);
    if (msg_ch.out_byte !== e.data) begin
      $display("%0t out_byte mismatch: expected %h actual %h", $time, e.data, msg_ch.out_byte);
      errors++;
    end
    if (msg_ch.in_header !== e.hdr) begin
      $display("%0t in_header mismatch: expected %b actual %b", $time, e.hdr, msg_ch.in_header);
      errors++;
    end
    if (msg_ch.msg_type !== e.mtype) begin
      $display("%0t msg_type mismatch: expected %h actual %h", $time, e.mtype, msg_ch.msg_type);
      errors++;
    end
    if (msg_ch.content_length !== e.mlen) begin
      $display("%0t content_length mismatch: expected %h actual %h",
               $time, e.mlen, msg_ch.content_length);
      errors++;
    end
    if (msg_ch.last !== e.eom) begin
      $display("%0t last mismatch: expected %b actual %b", $time, e.eom, msg_ch.last);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && msg_ch.valid && msg_ch.ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected transaction: expected none actual byte %h",
                 $time, msg_ch.out_byte);
        errors++;
      end else begin
        check_beat(pending_beats.pop_front());
        beats_checked++;
        if (msg_ch.last) msgs_closed++;
      end
    end
  end

  // receiver: random stall per transaction, or one long hold-off on request
  initial begin
    int unsigned n;
    msg_ch.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        msg_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = idle_on ? $urandom_range(0, 7) : 0;
        if (n != 0) begin
          msg_ch.ready = 1'b0;
          repeat (n) @(negedge clk_i);
        end
        msg_ch.ready = 1'b1;
        do @(posedge clk_i); while (!msg_ch.valid);
        @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_ch.valid && byte_ch.ready) || (msg_ch.valid && msg_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t timeout after %0d idle cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni                   = 1'b0;
    byte_ch.valid            = 1'b0;
    byte_ch.data_byte        = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.length_big_endian = 1'b0;
    be_order                 = 1'b0;
    hdr_pos                  = 0;
    type_sum                 = '0;
    len_sum                  = '0;
    body_left                = '0;
    idle_on                  = 1'b1;
    hold_req                 = 1'b0;
    errors                   = 0;
    bytes_sent               = 0;
    beats_checked            = 0;
    msgs_closed              = 0;
    cfg_writes               = 0;
    quiet_cycles             = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_little_endian();
    test_big_endian();
    test_back_pressure();
    test_random_streams();
    test_max_length();

    wait_drained();
    repeat (4) @(negedge clk_i);
    if (pending_beats.size() != 0) begin
      $display("%0t %0d transactions never arrived", $time, pending_beats.size());
      errors++;
    end
    $display("bytes sent %0d, results checked %0d, messages closed %0d, order writes %0d",
             bytes_sent, beats_checked, msgs_closed, cfg_writes);
    $display("both byte orders, zero length and all-ones length fields, long back pressure;"
             , " %0d errors", errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lpmd_pkg.sv
hw/rtl/lpmd_if.sv
hw/rtl/length_prefixed_message_deframer.sv
tb/tb_length_prefixed_message_deframer.sv
